FILE: design/pse_pkg.sv
// shared types and constants for the postfix stack evaluator
// used by pse_stack, pse_alu and postfix_stack_evaluator; no dependencies
`default_nettype none

package pse_pkg;

    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int LOOP_W      = $clog2(DATA_W);
    localparam int SYM_W       = 8;

    localparam logic [SYM_W-1:0] SYM_DIGIT_LO = 8'd49;
    localparam logic [SYM_W-1:0] SYM_DIGIT_HI = 8'd57;
    localparam logic [SYM_W-1:0] SYM_ZERO     = 8'h30;
    localparam logic [SYM_W-1:0] SYM_PLUS     = 8'h2b;
    localparam logic [SYM_W-1:0] SYM_MINUS    = 8'h2d;
    localparam logic [SYM_W-1:0] SYM_STAR     = 8'h2a;
    localparam logic [SYM_W-1:0] SYM_SLASH    = 8'h2f;
    localparam logic [SYM_W-1:0] SYM_PERCENT  = 8'h25;
    localparam logic [SYM_W-1:0] SYM_END      = 8'h23;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ADD,
        A_ABS_A,
        A_ABS_B,
        A_LOOP,
        A_FIX,
        A_DONE
    } t_alu_phase;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_alu_rsp;

endpackage

`default_nettype wire

FILE: design/pse_stack.sv
// value stack storage: one write port, one registered read port
// depends on pse_pkg
`default_nettype none

module pse_stack (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [pse_pkg::PTR_W-1:0] i_waddr,
    input  wire logic [pse_pkg::DATA_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [pse_pkg::PTR_W-1:0] i_raddr,
    output logic      [pse_pkg::DATA_W-1:0] o_rdata
);

    logic [pse_pkg::DATA_W-1:0] r_mem [pse_pkg::STACK_DEPTH];
    logic [pse_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/pse_alu.sv
// iterative arithmetic unit built around one shared 33-bit adder:
// add/sub in one pass, shift-add multiply and restoring divide over 32 steps
// depends on pse_pkg
`default_nettype none

module pse_alu (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire pse_pkg::t_alu_req          i_req,
    input  wire logic [pse_pkg::DATA_W-1:0] i_a,
    input  wire logic [pse_pkg::DATA_W-1:0] i_b,
    output pse_pkg::t_alu_rsp               o_rsp
);

    localparam int W = pse_pkg::DATA_W;

    pse_pkg::t_alu_phase r_phase, n_phase;
    pse_pkg::t_alu_op    r_op;
    logic [pse_pkg::LOOP_W-1:0] r_cnt;
    logic [W-1:0] r_acc;   // sum, product or remainder; quotient after the sign fix
    logic [W-1:0] r_x;     // multiplicand or dividend / quotient
    logic [W-1:0] r_y;     // multiplier or divisor
    logic         r_sa, r_sb;

    logic [W-1:0] add_x, add_y, rem_sh, fix_v;
    logic         add_cin, fix_neg, is_div, last_step;
    logic [W:0]   sum;

    assign is_div    = (r_op == pse_pkg::OP_DIV) || (r_op == pse_pkg::OP_MOD);
    assign last_step = (r_cnt == pse_pkg::LOOP_W'(W - 1));
    assign rem_sh    = {r_acc[W-2:0], r_x[W-1]};
    assign fix_v     = (r_op == pse_pkg::OP_DIV) ? r_x : r_acc;
    assign fix_neg   = (r_op == pse_pkg::OP_DIV) ? (r_sa ^ r_sb) : r_sa;

    // operand selection for the shared adder
    always_comb begin
        add_x   = r_x;
        add_y   = r_y;
        add_cin = 1'b0;
        unique case (r_phase)
            pse_pkg::A_ADD: begin
                add_y   = (r_op == pse_pkg::OP_SUB) ? ~r_y : r_y;
                add_cin = (r_op == pse_pkg::OP_SUB);
            end
            pse_pkg::A_ABS_A: begin
                add_x   = ~r_x;
                add_y   = '0;
                add_cin = 1'b1;
            end
            pse_pkg::A_ABS_B: begin
                add_x   = ~r_y;
                add_y   = '0;
                add_cin = 1'b1;
            end
            pse_pkg::A_LOOP: begin
                if (is_div) begin
                    add_x   = rem_sh;
                    add_y   = ~r_y;
                    add_cin = 1'b1;
                end else begin
                    add_x   = r_acc;
                    add_y   = r_x;
                end
            end
            pse_pkg::A_FIX: begin
                add_x   = ~fix_v;
                add_y   = '0;
                add_cin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_cin};

    // phase sequencing
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            pse_pkg::A_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == pse_pkg::OP_ADD || i_req.op == pse_pkg::OP_SUB) begin
                        n_phase = pse_pkg::A_ADD;
                    end else if (i_req.op == pse_pkg::OP_MUL) begin
                        n_phase = pse_pkg::A_LOOP;
                    end else begin
                        n_phase = pse_pkg::A_ABS_A;
                    end
                end
            end
            pse_pkg::A_ADD:   n_phase = pse_pkg::A_DONE;
            pse_pkg::A_ABS_A: n_phase = pse_pkg::A_ABS_B;
            pse_pkg::A_ABS_B: n_phase = pse_pkg::A_LOOP;
            pse_pkg::A_LOOP: begin
                if (last_step) begin
                    n_phase = is_div ? pse_pkg::A_FIX : pse_pkg::A_DONE;
                end
            end
            pse_pkg::A_FIX:   n_phase = pse_pkg::A_DONE;
            pse_pkg::A_DONE:  n_phase = pse_pkg::A_IDLE;
            default:          n_phase = pse_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pse_pkg::A_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            pse_pkg::A_IDLE: begin
                if (i_req.start) begin
                    r_op  <= i_req.op;
                    r_x   <= i_a;
                    r_y   <= i_b;
                    r_sa  <= i_a[W-1];
                    r_sb  <= i_b[W-1];
                    r_acc <= '0;
                    r_cnt <= '0;
                end
            end
            pse_pkg::A_ADD: begin
                r_acc <= sum[W-1:0];
            end
            pse_pkg::A_ABS_A: begin
                if (r_sa) begin
                    r_x <= sum[W-1:0];
                end
            end
            pse_pkg::A_ABS_B: begin
                if (r_sb) begin
                    r_y <= sum[W-1:0];
                end
            end
            pse_pkg::A_LOOP: begin
                r_cnt <= r_cnt + pse_pkg::LOOP_W'(1);
                if (is_div) begin
                    // carry out means the shifted remainder covers the divisor
                    r_acc <= sum[W] ? sum[W-1:0] : rem_sh;
                    r_x   <= {r_x[W-2:0], sum[W]};
                end else begin
                    if (r_y[0]) begin
                        r_acc <= sum[W-1:0];
                    end
                    r_x <= {r_x[W-2:0], 1'b0};
                    r_y <= {1'b0, r_y[W-1:1]};
                end
            end
            pse_pkg::A_FIX: begin
                r_acc <= fix_neg ? sum[W-1:0] : fix_v;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_rsp.done   = (r_phase == pse_pkg::A_DONE);
        o_rsp.result = r_acc;
    end

endmodule

`default_nettype wire

FILE: design/postfix_stack_evaluator.sv
// postfix evaluator: one character word in, one status/top-of-stack word out
// digits, '#', ignored bytes and error cases give the result word directly; +, -,
// *, / and % go through pse_alu, the last three over the 32 steps of its shared adder
// throughput: one word at a time, next word taken after the result word is taken
// reset (synchronous, active low) empties the stack; stack contents are not cleared
// depends on pse_pkg, pse_stack, pse_alu
`default_nettype none

module postfix_stack_evaluator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input word channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [pse_pkg::SYM_W-1:0]      i_symbol,
    // result word channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [pse_pkg::DATA_W-1:0]   o_top_value,
    output logic                                o_top_valid,
    output logic [1:0]                          o_status,
    output logic                                o_is_final
);

    localparam int W = pse_pkg::DATA_W;

    pse_pkg::t_state r_state, n_state;

    // stack pointer and a cached copy of the top entry
    logic [pse_pkg::CNT_W-1:0] r_count;
    logic [W-1:0]              r_top;
    pse_pkg::t_alu_op          r_op;

    // result word register
    logic [W-1:0]     r_out_value;
    logic             r_out_valid;
    pse_pkg::t_status r_out_status;
    logic             r_out_final;

    // symbol decode
    logic is_digit, is_end, is_oper;
    pse_pkg::t_alu_op sym_op;
    logic [W-1:0] digit_value;
    logic [W-1:0] cur_top;
    logic         stack_empty, stack_full, short_stack, top_zero, accept;

    logic [pse_pkg::CNT_W-1:0] below_idx;

    // stack memory and alu hookup
    logic                      mem_we, mem_re;
    logic [pse_pkg::PTR_W-1:0] mem_waddr;
    logic [W-1:0]              mem_wdata, mem_rdata;
    pse_pkg::t_alu_req         alu_req;
    pse_pkg::t_alu_rsp         alu_rsp;

    assign accept = i_valid && o_ready;

    assign is_digit = (i_symbol >= pse_pkg::SYM_DIGIT_LO) && (i_symbol <= pse_pkg::SYM_DIGIT_HI);
    assign is_end   = (i_symbol == pse_pkg::SYM_END);
    assign is_oper  = (i_symbol == pse_pkg::SYM_PLUS)  || (i_symbol == pse_pkg::SYM_MINUS) ||
                      (i_symbol == pse_pkg::SYM_STAR)  || (i_symbol == pse_pkg::SYM_SLASH) ||
                      (i_symbol == pse_pkg::SYM_PERCENT);
    assign digit_value = {{(W - pse_pkg::SYM_W){1'b0}}, i_symbol - pse_pkg::SYM_ZERO};

    always_comb begin
        priority if (i_symbol == pse_pkg::SYM_PLUS) begin
            sym_op = pse_pkg::OP_ADD;
        end else if (i_symbol == pse_pkg::SYM_MINUS) begin
            sym_op = pse_pkg::OP_SUB;
        end else if (i_symbol == pse_pkg::SYM_STAR) begin
            sym_op = pse_pkg::OP_MUL;
        end else if (i_symbol == pse_pkg::SYM_SLASH) begin
            sym_op = pse_pkg::OP_DIV;
        end else begin
            sym_op = pse_pkg::OP_MOD;
        end
    end

    assign stack_empty = (r_count == '0);
    assign stack_full  = (r_count == pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH));
    assign short_stack = (r_count < pse_pkg::CNT_W'(2));
    assign top_zero    = (r_top == '0);
    assign cur_top     = stack_empty ? '0 : r_top;

    // the entry just below the top, operand a of a binary operator
    assign below_idx = r_count - pse_pkg::CNT_W'(2);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pse_pkg::S_IDLE: begin
                if (accept) begin
                    // binary operator with two entries and a usable divisor goes to the alu
                    if (is_oper && !is_end && !short_stack &&
                        !(top_zero && (sym_op == pse_pkg::OP_DIV ||
                                       sym_op == pse_pkg::OP_MOD))) begin
                        n_state = pse_pkg::S_READ;
                    end else begin
                        n_state = pse_pkg::S_OUT;
                    end
                end
            end
            pse_pkg::S_READ: n_state = pse_pkg::S_WAIT;
            pse_pkg::S_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = pse_pkg::S_OUT;
                end
            end
            pse_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = pse_pkg::S_IDLE;
                end
            end
            default: n_state = pse_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control outputs of the sequencer
    always_comb begin
        o_ready   = (r_state == pse_pkg::S_IDLE);
        o_valid   = (r_state == pse_pkg::S_OUT);
        mem_re    = (r_state == pse_pkg::S_IDLE) && accept;
        alu_req.start = (r_state == pse_pkg::S_READ);
        alu_req.op    = r_op;
        mem_we    = 1'b0;
        mem_waddr = r_count[pse_pkg::PTR_W-1:0];
        mem_wdata = digit_value;
        if (r_state == pse_pkg::S_IDLE) begin
            // push a digit at the current count
            mem_we = accept && is_digit && !stack_full;
        end else if (r_state == pse_pkg::S_WAIT) begin
            // result replaces operand a, one below the top
            mem_we    = alu_rsp.done;
            mem_waddr = below_idx[pse_pkg::PTR_W-1:0];
            mem_wdata = alu_rsp.result;
        end
    end

    // stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            if (r_state == pse_pkg::S_IDLE && accept) begin
                if (is_end) begin
                    r_count <= '0;
                end else if (is_digit && !stack_full) begin
                    r_count <= r_count + pse_pkg::CNT_W'(1);
                end
            end else if (r_state == pse_pkg::S_WAIT && alu_rsp.done) begin
                r_count <= r_count - pse_pkg::CNT_W'(1);
            end
        end
    end

    // top cache, operator latch and result word
    always_ff @(posedge i_clk) begin
        if (r_state == pse_pkg::S_IDLE && accept) begin
            r_op         <= sym_op;
            r_out_final  <= is_end;
            r_out_status <= pse_pkg::ST_OK;
            r_out_value  <= cur_top;
            r_out_valid  <= !stack_empty;
            if (is_end) begin
                if (stack_empty) begin
                    r_out_status <= pse_pkg::ST_UNDERFLOW;
                end
            end else if (is_digit) begin
                if (stack_full) begin
                    r_out_status <= pse_pkg::ST_OVERFLOW;
                end else begin
                    r_top       <= digit_value;
                    r_out_value <= digit_value;
                    r_out_valid <= 1'b1;
                end
            end else if (is_oper) begin
                if (short_stack) begin
                    r_out_status <= pse_pkg::ST_UNDERFLOW;
                end else if (top_zero && (sym_op == pse_pkg::OP_DIV ||
                                          sym_op == pse_pkg::OP_MOD)) begin
                    r_out_status <= pse_pkg::ST_DIVZERO;
                end
            end
        end else if (r_state == pse_pkg::S_WAIT && alu_rsp.done) begin
            r_top       <= alu_rsp.result;
            r_out_value <= alu_rsp.result;
            r_out_valid <= 1'b1;
        end
    end

    pse_stack u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (below_idx[pse_pkg::PTR_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // operand a from memory, operand b from the top cache
    pse_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (mem_rdata),
        .i_b     (r_top),
        .o_rsp   (alu_rsp)
    );

    assign o_top_value = r_out_value;
    assign o_top_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_is_final  = r_out_final;

endmodule

`default_nettype wire
